// File: sv/ca_row_pkg.sv
`timescale 1ns / 1ps

package ca_row_pkg;

    localparam int CELLS_DEF  = 64;
    localparam int ROW_W      = 64;
    localparam int IDX_W      = 6;
    localparam int RESET_SEED = 32;
    localparam int RESET_TAP  = 32;

    typedef enum logic [1:0] {
        RULE_30    = 2'd0,
        RULE_57630 = 2'd1,
        RULE_39318 = 2'd2
    } t_rule;

    typedef enum logic [1:0] {
        CFG_RULE_SELECT   = 2'd0,
        CFG_ZERO_BOUNDARY = 2'd1,
        CFG_SEED_CELL     = 2'd2,
        CFG_TAP_CELL      = 2'd3
    } t_cfg_index;

endpackage

// File: sv/cellular_automaton_row_step.sv
`timescale 1ns / 1ps

// One-dimensional cellular automaton row of CELLS cells (cell i at bit i) with a
// random-bit tap. Each input transfer is one tick: reload puts a single one at
// seed_cell, otherwise every cell advances one generation at once under the
// selected rule (30, 57630 or 39318), with the row ends wrapping or reading as
// zero. The block takes one tick per clock while o_stall is low and delivers
// its result in the cycle after the transfer, from an output register; the
// row register is fed back through the neighbor logic in front of it. While a
// result is held by i_stall, o_stall is raised. Configuration writes are always
// ready and take effect for the next tick.
module cellular_automaton_row_step #(
    parameter int CELLS = ca_row_pkg::CELLS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [1:0]                  i_cfg_index,
    input  logic [ca_row_pkg::IDX_W-1:0] i_cfg_data,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic                        i_reload,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [ca_row_pkg::ROW_W-1:0] o_row,
    output logic                        o_tap_bit
);
    import ca_row_pkg::*;

    logic [1:0]       r_rule;
    logic             r_zero_bnd;
    logic [IDX_W-1:0] r_seed;
    logic [IDX_W-1:0] r_tap;
    logic [CELLS-1:0] r_cells;
    logic [CELLS-1:0] n_cells;
    logic [CELLS-1:0] rst_row;
    logic [CELLS-1:0] seed_row;
    logic [CELLS-1:0] gen_row;
    logic [CELLS-1:0] l1;
    logic [CELLS-1:0] l2;
    logic [CELLS-1:0] r1;
    logic [ROW_W-1:0] row_ext;
    logic             r_out_valid;
    logic [ROW_W-1:0] r_out_row;
    logic             r_out_tap;
    logic             in_xfer;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = r_out_valid & i_stall;
    assign in_xfer     = i_valid & ~o_stall;

    // neighbor taps, ends wrap unless the zero boundary is selected
    for (genvar gi = 0; gi < CELLS; gi++) begin : g_cell
        assign rst_row[gi]  = (gi == RESET_SEED);
        assign seed_row[gi] = (r_seed == IDX_W'(gi));
        if (gi >= 1) begin : g_l1
            assign l1[gi] = r_cells[gi-1];
        end else begin : g_l1w
            assign l1[gi] = ~r_zero_bnd & r_cells[CELLS-1];
        end
        if (gi >= 2) begin : g_l2
            assign l2[gi] = r_cells[gi-2];
        end else begin : g_l2w
            assign l2[gi] = ~r_zero_bnd & r_cells[CELLS-2+gi];
        end
        if (gi < CELLS-1) begin : g_r1
            assign r1[gi] = r_cells[gi+1];
        end else begin : g_r1w
            assign r1[gi] = ~r_zero_bnd & r_cells[0];
        end
    end

    always_comb begin
        case (r_rule)
            RULE_57630: gen_row = l2 ^ l1 ^ (r_cells | r1);
            RULE_39318: gen_row = r_cells ^ r1 ^ (l2 | l1);
            default:    gen_row = l1 ^ (r_cells | r1);
        endcase
    end

    assign n_cells = i_reload ? seed_row : gen_row;
    assign row_ext = ROW_W'(n_cells);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rule     <= RULE_30;
            r_zero_bnd <= 1'b0;
            r_seed     <= IDX_W'(RESET_SEED);
            r_tap      <= IDX_W'(RESET_TAP);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_RULE_SELECT:   r_rule     <= i_cfg_data[1:0];
                CFG_ZERO_BOUNDARY: r_zero_bnd <= i_cfg_data[0];
                CFG_SEED_CELL:     r_seed     <= i_cfg_data;
                CFG_TAP_CELL:      r_tap      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cells     <= rst_row;
            r_out_valid <= 1'b0;
        end else begin
            if (in_xfer) begin
                r_cells     <= n_cells;
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // bits at and above CELLS are zero, so an out-of-row tap reads zero
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_out_row <= row_ext;
            r_out_tap <= row_ext[r_tap];
        end
    end

    assign o_valid   = r_out_valid;
    assign o_row     = r_out_row;
    assign o_tap_bit = r_out_tap;

endmodule

// File: sv/ca_row_chk.sv
`timescale 1ns / 1ps

module ca_row_chk #(
    parameter int CELLS = 64
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        i_reload,
    input logic        o_valid,
    input logic        i_stall,
    input logic [63:0] o_row,
    input logic        o_tap_bit
);

    // a held result keeps its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_row) && $stable(o_tap_bit))
        else $error("held result changed");

    // every input transfer shows its result in the next cycle
    a_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_valid)
        else $error("missing result after input transfer");

    // stall only backs up a result that is itself stalled
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without a held result");

    // a reload gives at most one live cell
    a_reload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && i_reload |=> $onehot0(o_row))
        else $error("reload row is not one-hot");

    // cells past the end of the row stay zero
    a_unused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_row >> CELLS) == 64'd0)
        else $error("bits beyond the row are set");

endmodule

bind cellular_automaton_row_step ca_row_chk #(.CELLS(CELLS)) u_ca_row_chk (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_valid   (i_valid),
    .o_stall   (o_stall),
    .i_reload  (i_reload),
    .o_valid   (o_valid),
    .i_stall   (i_stall),
    .o_row     (o_row),
    .o_tap_bit (o_tap_bit)
);
